[hw/rtl/rlmc_pkg.sv]
// ----------------------------------------------------------------------------
// rlmc_pkg
// Shared types, constants and helpers of the RGBW LED mode controller.
// ----------------------------------------------------------------------------
package rlmc_pkg;

	localparam logic [7:0]  DUTY_MAX      = 8'd255;
	localparam logic [13:0] PERIOD_STEP   = 14'd50;
	localparam logic [13:0] PERIOD_BASE   = 14'd3000;
	localparam logic [13:0] PERIOD_RESET  = 14'd15000;
	localparam logic [7:0]  SPEC_HALF     = 8'd127;
	localparam logic [7:0]  SPEC_BLUE_CAP = 8'd143;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_TICK   = 2'd1,
		KIND_BUTTON = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_SOLID    = 2'd0,
		MODE_SPECTRUM = 2'd1,
		MODE_FADE     = 2'd2,
		MODE_AUDIO    = 2'd3
	} mode_t;

	// classified word handed from front to back
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  ch1;
		logic [7:0]  ch2;
		logic [7:0]  ch3;
		logic [7:0]  ch4;
		logic [7:0]  aud_red;
		logic [7:0]  aud_green;
		logic [7:0]  aud_blue;
		logic [13:0] period;
		logic        button;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  white;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		mode_t       mode;
		logic [13:0] period;
	} res_t;

	// x / 255 for x up to 255*255: (x + (x >> 8) + 1) >> 8
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + 17'(x[15:8]) + 17'd1;
		return t[15:8];
	endfunction

endpackage

[hw/rtl/rgbw_led_mode_controller.sv]
// ----------------------------------------------------------------------------
// rgbw_led_mode_controller
// Four-mode RGBW LED duty controller: solid, spectrum, fade and audio.
// ----------------------------------------------------------------------------
// channel   handshake       payload
// input     push / full     kind, ch1..ch6, button_level
// result    pop / empty     white_duty, red_duty, green_duty, blue_duty,
//                           mode, tick_period
//
// One word per cycle sustained while results are popped, one result per word.
// A pushed word waits in the input queue; its result is registered in the result queue.
// Front and back each hold a two-entry queue, so a stalled pop fills the
// result queue first and then the input queue before full rises.
// Reset is asynchronous; both queues come out of reset empty.
// ----------------------------------------------------------------------------
module rgbw_led_mode_controller import rlmc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  kind,
	input  logic [7:0]  ch1,
	input  logic [7:0]  ch2,
	input  logic [7:0]  ch3,
	input  logic [7:0]  ch4,
	input  logic [7:0]  ch5,
	input  logic [7:0]  ch6,
	input  logic        button_level,
	input  logic        pop,
	output logic        empty,
	output logic [7:0]  white_duty,
	output logic [7:0]  red_duty,
	output logic [7:0]  green_duty,
	output logic [7:0]  blue_duty,
	output logic [1:0]  mode,
	output logic [13:0] tick_period
);

	logic q_empty;
	logic take;
	cmd_t q_head;

	rlmc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.kind         (kind),
		.ch1          (ch1),
		.ch2          (ch2),
		.ch3          (ch3),
		.ch4          (ch4),
		.ch5          (ch5),
		.ch6          (ch6),
		.button_level (button_level),
		.take         (take),
		.q_empty      (q_empty),
		.q_head       (q_head)
	);

	rlmc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (~q_empty),
		.cmd         (q_head),
		.take        (take),
		.pop         (pop),
		.empty       (empty),
		.white_duty  (white_duty),
		.red_duty    (red_duty),
		.green_duty  (green_duty),
		.blue_duty   (blue_duty),
		.mode        (mode),
		.tick_period (tick_period)
	);

endmodule

[hw/rtl/rlmc_front.sv]
// ----------------------------------------------------------------------------
// rlmc_front
// Accepts input words, classifies them, precomputes the input-only products
// (audio duties, fade tick period) and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module rlmc_front import rlmc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] kind,
	input  logic [7:0] ch1,
	input  logic [7:0] ch2,
	input  logic [7:0] ch3,
	input  logic [7:0] ch4,
	input  logic [7:0] ch5,
	input  logic [7:0] ch6,
	input  logic       button_level,
	input  logic       take,
	output logic       q_empty,
	output cmd_t       q_head
);

	cmd_t       cmd;
	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       enq;
	logic       deq;

	always_comb begin
		cmd.kind      = kind_t'(kind);
		cmd.ch1       = ch1;
		cmd.ch2       = ch2;
		cmd.ch3       = ch3;
		cmd.ch4       = ch4;
		cmd.aud_red   = div255(16'(ch3) * 16'(ch5));
		cmd.aud_green = div255(16'(ch1) * 16'(ch5));
		cmd.aud_blue  = div255(16'(ch2) * 16'(ch5));
		cmd.period    = 14'(ch6) * PERIOD_STEP + PERIOD_BASE;
		cmd.button    = button_level;
	end

	assign full    = (cnt_q == 2'd2);
	assign q_empty = (cnt_q == 2'd0);
	assign q_head  = mem_q[rd_ptr_q];
	assign enq     = push & ~full;
	assign deq     = take & ~q_empty;

	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (enq) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (deq) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(enq) - 2'(deq);
		end
	end

endmodule

[hw/rtl/rlmc_back.sv]
// ----------------------------------------------------------------------------
// rlmc_back
// Carries out classified words against mode, fade, spectrum and button state,
// one per cycle while the results fit in its two-entry output queue.
// ----------------------------------------------------------------------------
module rlmc_back import rlmc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        take,
	input  logic        pop,
	output logic        empty,
	output logic [7:0]  white_duty,
	output logic [7:0]  red_duty,
	output logic [7:0]  green_duty,
	output logic [7:0]  blue_duty,
	output logic [1:0]  mode,
	output logic [13:0] tick_period
);

	typedef enum logic [2:0] {
		PH_GREEN_UP     = 3'd1,
		PH_GREEN_TOP    = 3'd2,
		PH_BLUE_DOWN    = 3'd3,
		PH_GREEN_TO_RED = 3'd4,
		PH_RED_TO_BLUE  = 3'd5,
		PH_RED_UP       = 3'd6,
		PH_RED_DOWN     = 3'd7
	} phase_t;

	mode_t       mode_q,    n_mode;
	logic [7:0]  level_q,   n_level;
	logic        rising_q,  n_rising;
	phase_t      phase_q,   n_phase;
	logic [7:0]  white_q,   n_white;
	logic [7:0]  red_q,     n_red;
	logic [7:0]  green_q,   n_green;
	logic [7:0]  blue_q,    n_blue;
	logic        pend_q,    n_pend;
	logic        prev_q,    n_prev;
	logic [13:0] period_q,  n_period;

	logic [7:0]  fade_w, fade_r, fade_g, fade_b;

	res_t        res;
	res_t        omem_q [2];
	logic        owr_q;
	logic        ord_q;
	logic [1:0]  ocnt_q;
	logic        odeq;
	res_t        head;

	function automatic logic [7:0] fade_scale(input logic [7:0] pot, input logic [7:0] lvl);
		logic [7:0] q;
		q = div255(16'(pot) * 16'(lvl));
		return (q == DUTY_MAX) ? DUTY_MAX : q + 8'd1;
	endfunction

	assign fade_w = fade_scale(cmd.ch4, level_q);
	assign fade_r = fade_scale(cmd.ch1, level_q);
	assign fade_g = fade_scale(cmd.ch2, level_q);
	assign fade_b = fade_scale(cmd.ch3, level_q);

	assign take = cmd_valid & (ocnt_q != 2'd2);

	always_comb begin
		n_mode   = mode_q;
		n_level  = level_q;
		n_rising = rising_q;
		n_phase  = phase_q;
		n_white  = white_q;
		n_red    = red_q;
		n_green  = green_q;
		n_blue   = blue_q;
		n_pend   = pend_q;
		n_prev   = prev_q;
		n_period = period_q;
		unique case (cmd.kind)
			KIND_SAMPLE: begin
				// a pending press is always consumed by a sample pass
				n_pend = 1'b0;
				unique case (mode_q)
					MODE_SOLID: begin
						n_white = cmd.ch4;
						if (pend_q) begin
							n_red   = 8'd0;
							n_green = 8'd0;
							n_blue  = DUTY_MAX;
							n_mode  = MODE_SPECTRUM;
						end else begin
							n_red   = cmd.ch1;
							n_green = cmd.ch2;
							n_blue  = cmd.ch3;
						end
					end
					MODE_SPECTRUM: begin
						if (pend_q) begin
							n_mode  = MODE_FADE;
							n_white = fade_w;
							n_red   = fade_r;
							n_green = fade_g;
							n_blue  = fade_b;
						end
					end
					MODE_FADE: begin
						if (pend_q) begin
							n_mode  = MODE_AUDIO;
							n_white = cmd.ch4;
							n_red   = cmd.aud_red;
							n_green = cmd.aud_green;
							n_blue  = cmd.aud_blue;
						end else begin
							n_white = fade_w;
							n_red   = fade_r;
							n_green = fade_g;
							n_blue  = fade_b;
						end
					end
					MODE_AUDIO: begin
						n_white = cmd.ch4;
						n_red   = cmd.aud_red;
						n_green = cmd.aud_green;
						n_blue  = cmd.aud_blue;
						if (pend_q) begin
							n_mode = MODE_SOLID;
						end
					end
					default: ;
				endcase
			end
			KIND_TICK: begin
				if (mode_q == MODE_FADE) begin
					n_period = cmd.period;
					if (n_rising && n_level != DUTY_MAX) n_level = n_level + 8'd1;
					if (n_rising && n_level == DUTY_MAX) n_rising = 1'b0;
					if (!n_rising && n_level != 8'd0) n_level = n_level - 8'd1;
					if (!n_rising && n_level == 8'd0) n_rising = 1'b1;
				end
				if (mode_q == MODE_SPECTRUM) begin
					n_white = cmd.ch4;
					// phases fall through within one tick
					if (n_phase == PH_GREEN_UP) begin
						n_green = n_green + 8'd1;
						if (n_green == SPEC_HALF) n_phase = PH_GREEN_TOP;
					end
					if (n_phase == PH_GREEN_TOP) begin
						n_green = n_green + 8'd1;
						if (n_green == DUTY_MAX) n_phase = PH_BLUE_DOWN;
					end
					if (n_phase == PH_BLUE_DOWN) begin
						n_blue = n_blue - 8'd1;
						if (n_blue == 8'd0) n_phase = PH_GREEN_TO_RED;
					end
					if (n_phase == PH_GREEN_TO_RED) begin
						n_green = n_green - 8'd1;
						n_red   = n_red + 8'd1;
						if (n_green == 8'd0) n_phase = PH_RED_TO_BLUE;
					end
					if (n_phase == PH_RED_TO_BLUE) begin
						n_blue = n_blue + 8'd1;
						n_red  = n_red - 8'd1;
						if (n_blue == SPEC_HALF) n_phase = PH_RED_UP;
					end
					if (n_phase == PH_RED_UP) begin
						n_red = n_red + 8'd1;
						if (n_blue < SPEC_BLUE_CAP) n_blue = n_blue + 8'd1;
						if (n_red == DUTY_MAX) n_phase = PH_RED_DOWN;
					end
					if (n_phase == PH_RED_DOWN) begin
						if (n_blue != DUTY_MAX) n_blue = n_blue + 8'd1;
						n_red = n_red - 8'd1;
						if (n_red == 8'd0) n_phase = PH_GREEN_UP;
					end
				end
			end
			KIND_BUTTON: begin
				// pin low: a press is pending only on the falling edge
				if (!cmd.button) n_pend = prev_q;
				n_prev = cmd.button;
			end
			KIND_NONE: ;
			default: ;
		endcase
	end

	always_comb begin
		res.white  = n_white;
		res.red    = n_red;
		res.green  = n_green;
		res.blue   = n_blue;
		res.mode   = n_mode;
		res.period = n_period;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_SOLID;
			level_q  <= 8'd0;
			rising_q <= 1'b1;
			phase_q  <= PH_GREEN_UP;
			white_q  <= 8'd0;
			red_q    <= 8'd0;
			green_q  <= 8'd0;
			blue_q   <= DUTY_MAX;
			pend_q   <= 1'b0;
			prev_q   <= 1'b0;
			period_q <= PERIOD_RESET;
		end else if (take) begin
			mode_q   <= n_mode;
			level_q  <= n_level;
			rising_q <= n_rising;
			phase_q  <= n_phase;
			white_q  <= n_white;
			red_q    <= n_red;
			green_q  <= n_green;
			blue_q   <= n_blue;
			pend_q   <= n_pend;
			prev_q   <= n_prev;
			period_q <= n_period;
		end
	end

	// output queue
	assign empty = (ocnt_q == 2'd0);
	assign odeq  = pop & ~empty;
	assign head  = omem_q[ord_q];

	assign white_duty  = head.white;
	assign red_duty    = head.red;
	assign green_duty  = head.green;
	assign blue_duty   = head.blue;
	assign mode        = head.mode;
	assign tick_period = head.period;

	always_ff @(posedge clk) begin
		if (take) begin
			omem_q[owr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (take) begin
				owr_q <= ~owr_q;
			end
			if (odeq) begin
				ord_q <= ~ord_q;
			end
			ocnt_q <= ocnt_q + 2'(take) - 2'(odeq);
		end
	end

endmodule

[hw/rtl/rlmc_checker.sv]
// ----------------------------------------------------------------------------
// rlmc_checker
// Port-level checks of the RGBW LED mode controller, bound to the top level.
// ----------------------------------------------------------------------------
module rlmc_checker import rlmc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        pop,
	input logic        empty,
	input logic [7:0]  white_duty,
	input logic [7:0]  red_duty,
	input logic [7:0]  green_duty,
	input logic [7:0]  blue_duty,
	input logic [1:0]  mode,
	input logic [13:0] tick_period
);

	// a waiting word holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(white_duty) && $stable(red_duty)
			&& $stable(green_duty) && $stable(blue_duty) && $stable(mode)
			&& $stable(tick_period)))
		else $error("result word changed while stalled");

	// period is either the reset value or a fade-rate setting
	a_period: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (tick_period >= PERIOD_BASE && tick_period <= 14'd15750))
		else $error("tick period out of range");

	// fade duties are always at least one
	a_fade_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && mode == MODE_FADE) |-> (white_duty != 8'd0 && red_duty != 8'd0
			&& green_duty != 8'd0 && blue_duty != 8'd0))
		else $error("zero duty in fade mode");

	// input side backs up only while a result is waiting
	a_full_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		(push && full) |-> !empty)
		else $error("input full while no result waits");

	// nothing comes out right after reset
	a_reset_empty: assert property (@(posedge clk) $rose(arst_n) |-> empty)
		else $error("result present right after reset");

endmodule

bind rgbw_led_mode_controller rlmc_checker u_rlmc_checker (.*);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RGBW LED mode controller. A short table of
// directed words walks every mode, the press edge rules and the duty extremes.
// Random episodes follow, with long timer-tick runs in spectrum and fade. Each
// accepted word is run through a local duty predictor, and every popped result
// is compared field by field. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rlmc_pkg::*;

	localparam int N_RANDOM = 700;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] c1, c2, c3, c4, c5, c6;
		logic       btn;
	} word_t;

	typedef struct {
		word_t w;
		bit    typed;
		res_t  want;
	} row_t;

	typedef enum logic [2:0] {
		WH_IDLE         = 3'd0,
		WH_GREEN_UP     = 3'd1,
		WH_GREEN_TOP    = 3'd2,
		WH_BLUE_DOWN    = 3'd3,
		WH_GREEN_TO_RED = 3'd4,
		WH_RED_TO_BLUE  = 3'd5,
		WH_RED_UP       = 3'd6,
		WH_RED_DOWN     = 3'd7
	} wheel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  kind = 2'd0;
	logic [7:0]  ch1 = 8'd0;
	logic [7:0]  ch2 = 8'd0;
	logic [7:0]  ch3 = 8'd0;
	logic [7:0]  ch4 = 8'd0;
	logic [7:0]  ch5 = 8'd0;
	logic [7:0]  ch6 = 8'd0;
	logic        button_level = 1'b0;
	logic        pop = 1'b0;
	logic        empty;
	logic [7:0]  white_duty;
	logic [7:0]  red_duty;
	logic [7:0]  green_duty;
	logic [7:0]  blue_duty;
	logic [1:0]  mode;
	logic [13:0] tick_period;

	// predicted controller state
	mode_t       md = MODE_SOLID;
	logic [7:0]  lvl = 8'd0;
	logic        rising = 1'b1;
	wheel_t      ph = WH_GREEN_UP;
	logic [7:0]  dw = 8'd0;
	logic [7:0]  dr = 8'd0;
	logic [7:0]  dg = 8'd0;
	logic [7:0]  db = DUTY_MAX;
	logic        pend = 1'b0;
	logic        prev = 1'b0;
	logic [13:0] per = PERIOD_RESET;

	res_t leds_due[$];
	int   n_diffs = 0;
	int   n_words = 0;
	int   pop_hold = 0;
	bit   calm = 1'b0;

	row_t steps [26] = '{
		'{'{KIND_NONE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 1'b1,
			'{8'd0, 8'd0, 8'd0, DUTY_MAX, MODE_SOLID, PERIOD_RESET}},
		'{'{KIND_SAMPLE, DUTY_MAX, DUTY_MAX, DUTY_MAX, DUTY_MAX, DUTY_MAX, DUTY_MAX, 1'b1},
			1'b1, '{DUTY_MAX, DUTY_MAX, DUTY_MAX, DUTY_MAX, MODE_SOLID, PERIOD_RESET}},
		'{'{KIND_SAMPLE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 1'b1,
			'{8'd0, 8'd0, 8'd0, 8'd0, MODE_SOLID, PERIOD_RESET}},
		// tick in solid changes nothing, period included
		'{'{KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, DUTY_MAX, 1'b0}, 1'b1,
			'{8'd0, 8'd0, 8'd0, 8'd0, MODE_SOLID, PERIOD_RESET}},
		'{'{KIND_BUTTON, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1}, 1'b1,
			'{8'd0, 8'd0, 8'd0, 8'd0, MODE_SOLID, PERIOD_RESET}},
		'{'{KIND_BUTTON, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 1'b1,
			'{8'd0, 8'd0, 8'd0, 8'd0, MODE_SOLID, PERIOD_RESET}},
		'{'{KIND_SAMPLE, 8'd10, 8'd20, 8'd30, 8'd40, 8'd0, 8'd0, 1'b1}, 1'b1,
			'{8'd40, 8'd0, 8'd0, DUTY_MAX, MODE_SPECTRUM, PERIOD_RESET}},
		'{'{KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd170, 8'd0, 8'd0, 1'b0}, 1'b0, '0},
		'{'{KIND_SAMPLE, DUTY_MAX, DUTY_MAX, DUTY_MAX, DUTY_MAX, DUTY_MAX, DUTY_MAX, 1'b1},
			1'b0, '0},
		'{'{KIND_BUTTON, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1}, 1'b0, '0},
		'{'{KIND_BUTTON, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 1'b0, '0},
		// pin still low: the pending press is dropped
		'{'{KIND_BUTTON, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 1'b0, '0},
		'{'{KIND_SAMPLE, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 1'b0}, 1'b0, '0},
		'{'{KIND_BUTTON, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1}, 1'b0, '0},
		'{'{KIND_BUTTON, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 1'b0, '0},
		// into fade at level zero: every duty is one
		'{'{KIND_SAMPLE, DUTY_MAX, DUTY_MAX, DUTY_MAX, DUTY_MAX, 8'd0, 8'd0, 1'b0}, 1'b1,
			'{8'd1, 8'd1, 8'd1, 8'd1, MODE_FADE, PERIOD_RESET}},
		'{'{KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, DUTY_MAX, 1'b1}, 1'b1,
			'{8'd1, 8'd1, 8'd1, 8'd1, MODE_FADE, 14'd15750}},
		'{'{KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 1'b1,
			'{8'd1, 8'd1, 8'd1, 8'd1, MODE_FADE, PERIOD_BASE}},
		'{'{KIND_SAMPLE, DUTY_MAX, 8'd128, 8'd0, DUTY_MAX, 8'd0, 8'd0, 1'b0}, 1'b0, '0},
		'{'{KIND_BUTTON, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1}, 1'b0, '0},
		'{'{KIND_BUTTON, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 1'b0, '0},
		// fade to audio in one pass, audio duties come out at once
		'{'{KIND_SAMPLE, 8'd200, 8'd100, DUTY_MAX, 8'd7, DUTY_MAX, 8'd0, 1'b0}, 1'b1,
			'{8'd7, DUTY_MAX, 8'd200, 8'd100, MODE_AUDIO, PERIOD_BASE}},
		'{'{KIND_SAMPLE, DUTY_MAX, DUTY_MAX, DUTY_MAX, DUTY_MAX, 8'd0, 8'd0, 1'b0}, 1'b1,
			'{DUTY_MAX, 8'd0, 8'd0, 8'd0, MODE_AUDIO, PERIOD_BASE}},
		'{'{KIND_BUTTON, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1}, 1'b0, '0},
		'{'{KIND_BUTTON, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 1'b0, '0},
		// audio to solid keeps the audio duties for this pass
		'{'{KIND_SAMPLE, 8'd9, 8'd9, 8'd9, 8'd3, DUTY_MAX, 8'd0, 1'b0}, 1'b1,
			'{8'd3, 8'd9, 8'd9, 8'd9, MODE_SOLID, PERIOD_BASE}}
	};

	rgbw_led_mode_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.kind(kind),
		.ch1(ch1),
		.ch2(ch2),
		.ch3(ch3),
		.ch4(ch4),
		.ch5(ch5),
		.ch6(ch6),
		.button_level(button_level),
		.pop(pop),
		.empty(empty),
		.white_duty(white_duty),
		.red_duty(red_duty),
		.green_duty(green_duty),
		.blue_duty(blue_duty),
		.mode(mode),
		.tick_period(tick_period)
	);

	always #10 clk = ~clk;

	function automatic logic [7:0] fade_of(input logic [7:0] pot);
		int v;
		v = (int'(pot) * int'(lvl)) / 255 + 1;
		return (v > 255) ? DUTY_MAX : 8'(v);
	endfunction

	function automatic logic [7:0] audio_of(input logic [7:0] pot, input logic [7:0] gain);
		return 8'((int'(pot) * int'(gain)) / 255);
	endfunction

	// advance the predicted state by one word, return the duties it leaves
	function automatic res_t next_leds(input word_t w);
		case (w.kind)
		KIND_SAMPLE: begin
			if (md == MODE_SOLID) begin
				dw = w.c4;
				dr = w.c1;
				dg = w.c2;
				db = w.c3;
				if (pend) begin
					pend = 1'b0;
					dr = 8'd0;
					dg = 8'd0;
					db = DUTY_MAX;
					md = MODE_SPECTRUM;
				end
			end
			if (md == MODE_SPECTRUM && pend) begin
				pend = 1'b0;
				md = MODE_FADE;
			end
			if (md == MODE_FADE) begin
				dw = fade_of(w.c4);
				dr = fade_of(w.c1);
				dg = fade_of(w.c2);
				db = fade_of(w.c3);
				if (pend) begin
					pend = 1'b0;
					md = MODE_AUDIO;
				end
			end
			if (md == MODE_AUDIO) begin
				db = audio_of(w.c2, w.c5);
				dg = audio_of(w.c1, w.c5);
				dr = audio_of(w.c3, w.c5);
				dw = w.c4;
				if (pend) begin
					pend = 1'b0;
					md = MODE_SOLID;
				end
			end
		end
		KIND_TICK: begin
			if (md == MODE_FADE) begin
				per = 14'(int'(w.c6) * int'(PERIOD_STEP) + int'(PERIOD_BASE));
				if (rising && lvl != DUTY_MAX) lvl = lvl + 8'd1;
				if (rising && lvl == DUTY_MAX) rising = 1'b0;
				if (!rising && lvl != 8'd0) lvl = lvl - 8'd1;
				if (!rising && lvl == 8'd0) rising = 1'b1;
			end
			if (md == MODE_SPECTRUM) begin
				dw = w.c4;
				// phases fall through in order within one tick
				if (ph == WH_GREEN_UP) begin
					dg = dg + 8'd1;
					if (dg == SPEC_HALF) ph = WH_GREEN_TOP;
				end
				if (ph == WH_GREEN_TOP) begin
					dg = dg + 8'd1;
					if (dg == DUTY_MAX) ph = WH_BLUE_DOWN;
				end
				if (ph == WH_BLUE_DOWN) begin
					db = db - 8'd1;
					if (db == 8'd0) ph = WH_GREEN_TO_RED;
				end
				if (ph == WH_GREEN_TO_RED) begin
					dg = dg - 8'd1;
					dr = dr + 8'd1;
					if (dg == 8'd0) ph = WH_RED_TO_BLUE;
				end
				if (ph == WH_RED_TO_BLUE) begin
					db = db + 8'd1;
					dr = dr - 8'd1;
					if (db == SPEC_HALF) ph = WH_RED_UP;
				end
				if (ph == WH_RED_UP) begin
					dr = dr + 8'd1;
					if (db < SPEC_BLUE_CAP) db = db + 8'd1;
					if (dr == DUTY_MAX) ph = WH_RED_DOWN;
				end
				if (ph == WH_RED_DOWN) begin
					if (db != DUTY_MAX) db = db + 8'd1;
					dr = dr - 8'd1;
					if (dr == 8'd0) ph = WH_GREEN_UP;
				end
			end
		end
		KIND_BUTTON: begin
			if (!w.btn) pend = prev;
			prev = w.btn;
		end
		default: begin
		end
		endcase
		return '{dw, dr, dg, db, md, per};
	endfunction

	function automatic logic [7:0] pick_ch();
		case ($urandom_range(0, 9))
		0: return 8'd0;
		1: return DUTY_MAX;
		default: return 8'($urandom);
		endcase
	endfunction

	function automatic word_t rand_word(input int tick_pct);
		word_t w;
		int r;
		r = $urandom_range(0, 99);
		w.c1 = pick_ch();
		w.c2 = pick_ch();
		w.c3 = pick_ch();
		w.c4 = pick_ch();
		w.c5 = pick_ch();
		w.c6 = pick_ch();
		w.btn = 1'($urandom);
		if (r < tick_pct) w.kind = KIND_TICK;
		else if (r < tick_pct + (100 - tick_pct) / 2) w.kind = KIND_SAMPLE;
		else if (r < 95) w.kind = KIND_BUTTON;
		else w.kind = KIND_NONE;
		return w;
	endfunction

	task automatic flag_diff(input string msg);
		n_diffs++;
		$display("%0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want) flag_diff($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	// called right after a falling edge; returns right after a falling edge
	task automatic send_word(input word_t w, input bit typed, input res_t want);
		int gap;
		res_t got;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		kind <= w.kind;
		ch1 <= w.c1;
		ch2 <= w.c2;
		ch3 <= w.c3;
		ch4 <= w.c4;
		ch5 <= w.c5;
		ch6 <= w.c6;
		button_level <= w.btn;
		@(posedge clk);
		while (full) @(posedge clk);
		got = next_leds(w);
		leds_due.push_back(typed ? want : got);
		n_words++;
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		push <= 1'b0;
		while (leds_due.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop_hold > 0) begin
			pop <= 1'b0;
			pop_hold--;
		end else begin
			pop <= 1'b1;
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && pop && !empty) begin
			pop_hold = calm ? 0 : $urandom_range(0, 3);
			if (leds_due.size() == 0) begin
				flag_diff("result word popped with nothing pending");
			end else begin
				want = leds_due.pop_front();
				check_field("white_duty", white_duty, want.white);
				check_field("red_duty", red_duty, want.red);
				check_field("green_duty", green_duty, want.green);
				check_field("blue_duty", blue_duty, want.blue);
				check_field("mode", mode, want.mode);
				check_field("tick_period", tick_period, want.period);
			end
		end
	end

	initial begin
		word_t w;
		int len;
		int pct;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (steps[i]) send_word(steps[i].w, steps[i].typed, steps[i].want);
		hold_until_drained();
		while (n_words < $size(steps) + N_RANDOM) begin
			calm = ($urandom_range(0, 3) == 0);
			w = rand_word(0);
			w.kind = KIND_BUTTON;
			w.btn = 1'b1;
			send_word(w, 1'b0, '0);
			w.btn = 1'b0;
			send_word(w, 1'b0, '0);
			// sometimes the pin stays low, which cancels the press
			if ($urandom_range(0, 3) == 0) send_word(w, 1'b0, '0);
			w = rand_word(0);
			w.kind = KIND_SAMPLE;
			send_word(w, 1'b0, '0);
			// tick-driven modes get long runs so the wheel and the fade ramp move far
			if (md == MODE_SPECTRUM || md == MODE_FADE) begin
				len = $urandom_range(60, 250);
				pct = 80;
			end else begin
				len = $urandom_range(8, 30);
				pct = 30;
			end
			if (len > $size(steps) + N_RANDOM - n_words) len = $size(steps) + N_RANDOM - n_words;
			repeat (len) send_word(rand_word(pct), 1'b0, '0);
			if ($urandom_range(0, 7) == 0) hold_until_drained();
		end
		push <= 1'b0;
		while (leds_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (n_diffs == 0 && leds_due.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/rlmc_pkg.sv
hw/rtl/rlmc_front.sv
hw/rtl/rlmc_back.sv
hw/rtl/rgbw_led_mode_controller.sv
hw/rtl/rlmc_checker.sv
tb/tb_top.sv
